>>> rtl/dtyp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtyp_pkg
// Shared types, constants and helpers for the direction to yaw/pitch core.
// ----------------------------------------------------------------------------
package dtyp_pkg;

  // angle accumulator: signed, 1/65536 degree
  localparam int ANG_W = 26;

  // result field widths
  localparam int YAW_W      = 17;
  localparam int PITCH_W    = 18;
  localparam int OUT_DATA_W = 8 * ((YAW_W + PITCH_W + 7) / 8);
  localparam int OUT_PAD_W  = OUT_DATA_W - YAW_W - PITCH_W;

  // coordinate scaling: x and y by 2^24, z by the cordic gain in 24 fraction bits
  localparam int COORD_SHIFT = 24;
  localparam int KQ_W        = 26;
  localparam logic signed [KQ_W-1:0] KQ = 26'sd27628053;

  // angle constants in accumulator units
  localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] FULL_TURN = 26'sd23592960;
  localparam logic [ANG_W-1:0]        ROUND_BIAS = 26'd128;

  // output angle constants in 1/256 degree
  localparam logic [PITCH_W-1:0] OUT_TURN = 18'd92160;
  localparam logic [PITCH_W-1:0] DEG_90   = 18'd23040;
  localparam logic [PITCH_W-1:0] DEG_270  = 18'd69120;

  // atan(2^-i) in degrees times 65536, rounded
  localparam logic signed [ANG_W-1:0] ATAN_TAB [32] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0
  };

  // per-item flags that ride along the cell chain
  typedef struct packed {
    logic zero_xy;  // horizontal part is zero
    logic z_pos;    // z strictly positive
  } dtyp_flags_t;

  localparam int FLAGS_W = $bits(dtyp_flags_t);

  // fold into 0..360, round half up to 1/256 degree, full turn wraps to zero
  function automatic logic [YAW_W-1:0] round_angle(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] a_wrap;
    logic [ANG_W-1:0]        biased;
    logic [ANG_W-9:0]        r;
    a_wrap = a[ANG_W-1] ? (a + FULL_TURN) : a;
    biased = $unsigned(a_wrap) + ROUND_BIAS;
    r      = biased[ANG_W-1:8];
    if (r >= OUT_TURN) begin
      r = '0;
    end
    return r[YAW_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/dtyp_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtyp_prep
// Input stage: scales the vector, folds x into the right half plane and
// flags the zero horizontal case and a strictly positive z.
// ----------------------------------------------------------------------------
module dtyp_prep #(
  parameter int CW = 24,
  parameter int W  = 53
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire                              in_valid,
  input  wire  signed [CW-1:0]             dir_x,
  input  wire  signed [CW-1:0]             dir_y,
  input  wire  signed [CW-1:0]             dir_z,
  output logic                             out_valid,
  output logic signed [W-1:0]              out_x,
  output logic signed [W-1:0]              out_y,
  output logic signed [dtyp_pkg::ANG_W-1:0] out_ang,
  output logic signed [W-1:0]              out_z,
  output dtyp_pkg::dtyp_flags_t            out_flags
);
  import dtyp_pkg::*;

  logic signed [W-1:0]       x_scaled;
  logic signed [W-1:0]       y_scaled;
  logic signed [CW+KQ_W-1:0] z_prod;
  logic                      x_neg;

  // scale x and y by 2^24, z by the gain constant
  always_comb begin
    x_scaled = W'(dir_x) <<< COORD_SHIFT;
    y_scaled = W'(dir_y) <<< COORD_SHIFT;
    z_prod   = dir_z * KQ;
    x_neg    = dir_x[CW-1];
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_x             <= x_neg ? -x_scaled : x_scaled;
      out_y             <= x_neg ? -y_scaled : y_scaled;
      out_ang           <= x_neg ? HALF_TURN : '0;
      out_z             <= W'(z_prod);
      out_flags.zero_xy <= (dir_x == '0) && (dir_y == '0);
      out_flags.z_pos   <= !dir_z[CW-1] && (dir_z != '0);
    end
  end

endmodule
`default_nettype wire

>>> rtl/dtyp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtyp_cell
// One cordic vectoring iteration with a fixed shift, registered, passing
// side data to the next cell unchanged.
// ----------------------------------------------------------------------------
module dtyp_cell #(
  parameter int W     = 53,
  parameter int SW    = 8,
  parameter int SHIFT = 0
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               en,
  input  wire                               in_valid,
  input  wire  signed [W-1:0]               in_x,
  input  wire  signed [W-1:0]               in_y,
  input  wire  signed [dtyp_pkg::ANG_W-1:0] in_ang,
  input  wire         [SW-1:0]              in_side,
  output logic                              out_valid,
  output logic signed [W-1:0]               out_x,
  output logic signed [W-1:0]               out_y,
  output logic signed [dtyp_pkg::ANG_W-1:0] out_ang,
  output logic        [SW-1:0]              out_side
);
  import dtyp_pkg::*;

  localparam logic signed [ANG_W-1:0] STEP = ATAN_TAB[SHIFT];

  logic signed [W-1:0]     xs;
  logic signed [W-1:0]     ys;
  logic                    y_pos;
  logic signed [W-1:0]     x_next;
  logic signed [W-1:0]     y_next;
  logic signed [ANG_W-1:0] ang_next;

  // rotate toward y = 0, both updates from the old x and y
  always_comb begin
    xs    = in_x >>> SHIFT;
    ys    = in_y >>> SHIFT;
    y_pos = !in_y[W-1] && (in_y != '0);
    if (y_pos) begin
      x_next   = in_x + ys;
      y_next   = in_y - xs;
      ang_next = in_ang + STEP;
    end else begin
      x_next   = in_x - ys;
      y_next   = in_y + xs;
      ang_next = in_ang - STEP;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_ang  <= ang_next;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dtyp_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtyp_finish
// Output register: rounds both angles, applies the zero horizontal case and
// negates the pitch.
// ----------------------------------------------------------------------------
module dtyp_finish (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               en,
  input  wire                               in_valid,
  input  wire  signed [dtyp_pkg::ANG_W-1:0] yaw_ang,
  input  wire  signed [dtyp_pkg::ANG_W-1:0] pitch_ang,
  input  dtyp_pkg::dtyp_flags_t             flags,
  output logic                              out_valid,
  output logic        [dtyp_pkg::YAW_W-1:0] yaw_angle,
  output logic signed [dtyp_pkg::PITCH_W-1:0] neg_pitch_angle
);
  import dtyp_pkg::*;

  logic [YAW_W-1:0]   yaw_next;
  logic [PITCH_W-1:0] pitch_pos;

  // rounding and special case selection
  always_comb begin
    if (flags.zero_xy) begin
      yaw_next  = '0;
      pitch_pos = flags.z_pos ? DEG_90 : DEG_270;
    end else begin
      yaw_next  = round_angle(yaw_ang);
      pitch_pos = PITCH_W'(round_angle(pitch_ang));
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      yaw_angle       <= yaw_next;
      neg_pitch_angle <= $signed(PITCH_W'(0) - pitch_pos);
    end
  end

endmodule
`default_nettype wire

>>> rtl/direction_to_yaw_pitch_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// direction_to_yaw_pitch_core
// Direction vector to yaw and negated pitch by two chained cordic
// vectoring passes, one cell per iteration.
// ----------------------------------------------------------------------------
// pipeline: one input stage, one cell per iteration for the yaw pass and the
//   pitch pass, one output stage
// throughput: one item per cycle; the whole chain advances together and holds
//   only while a finished item waits at the output
// reset: synchronous, clears every valid flag; payload registers are not reset
// ----------------------------------------------------------------------------
module direction_to_yaw_pitch_core #(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 20
) (
  input  wire                                          clk,
  input  wire                                          rst,
  // s_tdata: dir_x, dir_y, dir_z (COORD_WIDTH each, signed), zero pad
  input  wire  [8*((3*COORD_WIDTH+7)/8)-1:0]           s_tdata,
  input  wire                                          s_tvalid,
  output logic                                         s_tready,
  // m_tdata: yaw_angle [16:0] unsigned, neg_pitch_angle [34:17] signed, zero pad
  output logic [dtyp_pkg::OUT_DATA_W-1:0]              m_tdata,
  output logic                                         m_tvalid,
  input  wire                                          m_tready
);
  import dtyp_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int W   = COORD_WIDTH + 29;
  localparam int YSW = W + FLAGS_W;
  localparam int PSW = ANG_W + FLAGS_W;

  logic en;

  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;
  logic signed [CW-1:0] dir_z;

  logic                    prep_valid;
  logic signed [W-1:0]     prep_x;
  logic signed [W-1:0]     prep_y;
  logic signed [ANG_W-1:0] prep_ang;
  logic signed [W-1:0]     prep_z;
  dtyp_flags_t             prep_flags;

  // yaw chain taps
  logic                    yv   [CORDIC_STEPS+1];
  logic signed [W-1:0]     yx   [CORDIC_STEPS+1];
  logic signed [W-1:0]     yy   [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] ya   [CORDIC_STEPS+1];
  logic [YSW-1:0]          ys   [CORDIC_STEPS+1];

  // pitch chain taps
  logic                    pv   [CORDIC_STEPS+1];
  logic signed [W-1:0]     px   [CORDIC_STEPS+1];
  logic signed [W-1:0]     py   [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] pa   [CORDIC_STEPS+1];
  logic [PSW-1:0]          ps   [CORDIC_STEPS+1];

  logic                       yaw_z_valid;
  dtyp_flags_t                fin_flags;
  logic [YAW_W-1:0]           yaw_angle;
  logic signed [PITCH_W-1:0]  neg_pitch_angle;

  // chain advances unless a finished item is held at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input fields
  assign dir_x = s_tdata[CW-1:0];
  assign dir_y = s_tdata[2*CW-1:CW];
  assign dir_z = s_tdata[3*CW-1:2*CW];

  dtyp_prep #(.CW(CW), .W(W)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .out_valid (prep_valid),
    .out_x     (prep_x),
    .out_y     (prep_y),
    .out_ang   (prep_ang),
    .out_z     (prep_z),
    .out_flags (prep_flags)
  );

  // yaw pass entry
  assign yv[0] = prep_valid;
  assign yx[0] = prep_x;
  assign yy[0] = prep_y;
  assign ya[0] = prep_ang;
  assign ys[0] = {prep_flags, prep_z};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_yaw
    dtyp_cell #(.W(W), .SW(YSW), .SHIFT(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (yv[i]),
      .in_x      (yx[i]),
      .in_y      (yy[i]),
      .in_ang    (ya[i]),
      .in_side   (ys[i]),
      .out_valid (yv[i+1]),
      .out_x     (yx[i+1]),
      .out_y     (yy[i+1]),
      .out_ang   (ya[i+1]),
      .out_side  (ys[i+1])
    );
  end

  // pitch pass entry: gain-scaled length against scaled z, yaw rides along
  assign yaw_z_valid = yv[CORDIC_STEPS];
  assign pv[0] = yaw_z_valid;
  assign px[0] = yx[CORDIC_STEPS];
  assign py[0] = ys[CORDIC_STEPS][W-1:0];
  assign pa[0] = '0;
  assign ps[0] = {ys[CORDIC_STEPS][YSW-1:W], ya[CORDIC_STEPS]};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pitch
    dtyp_cell #(.W(W), .SW(PSW), .SHIFT(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (pv[i]),
      .in_x      (px[i]),
      .in_y      (py[i]),
      .in_ang    (pa[i]),
      .in_side   (ps[i]),
      .out_valid (pv[i+1]),
      .out_x     (px[i+1]),
      .out_y     (py[i+1]),
      .out_ang   (pa[i+1]),
      .out_side  (ps[i+1])
    );
  end

  assign fin_flags = dtyp_flags_t'(ps[CORDIC_STEPS][PSW-1:ANG_W]);

  dtyp_finish u_finish (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (pv[CORDIC_STEPS]),
    .yaw_ang         (ps[CORDIC_STEPS][ANG_W-1:0]),
    .pitch_ang       (pa[CORDIC_STEPS]),
    .flags           (fin_flags),
    .out_valid       (m_tvalid),
    .yaw_angle       (yaw_angle),
    .neg_pitch_angle (neg_pitch_angle)
  );

  // output packing
  assign m_tdata = {OUT_PAD_W'(0), neg_pitch_angle, yaw_angle};

  // no item leaves the chain right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // yaw stays below a full turn
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (yaw_angle < OUT_TURN[YAW_W-1:0]))
    else $error("yaw out of range");

  // negated pitch stays in (-360, 0]
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!neg_pitch_angle[PITCH_W-1] ? (neg_pitch_angle == '0)
                  : (neg_pitch_angle > -$signed(OUT_TURN))))
    else $error("negated pitch out of range");

  // a held result stays valid with the input stalled until it is taken
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && !s_tready) || m_tready)
    else $error("output stage lost a held item");

endmodule
`default_nettype wire
